// ===== hw/rtl/srgb_pkg.sv =====
package srgb_pkg;

    localparam int DEF_MAX_WIDTH   = 4096;
    localparam int DEF_LINEAR_BITS = 16;
    localparam int MAX_HEIGHT      = 16384;
    localparam int WIDTH_BITS      = 13;
    localparam int HEIGHT_BITS     = 15;
    localparam int CFG_DATA_BITS   = 15;
    localparam int CFG_INDEX_BITS  = 2;
    localparam int QUEUE_DEPTH     = 4;
    localparam int SEARCH_STAGES   = 8;

    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SRGB_MODE    = 2'd2;

    localparam logic [WIDTH_BITS-1:0]  RESET_WIDTH  = 13'd4096;
    localparam logic [HEIGHT_BITS-1:0] RESET_HEIGHT = 15'd4096;

    typedef struct packed {
        logic last;
        logic srgb;
    } blk_ctl_t;

    // sign of p^5 * q^12 - r^5 * s^12
    function automatic int cmp_powers(longint unsigned p, longint unsigned q,
                                      longint unsigned r, longint unsigned s);
        logic [319:0] a;
        logic [319:0] b;
        a = 320'd1;
        b = 320'd1;
        for (int t = 0; t < 5; t++)
        begin
            a = a * p;
            b = b * r;
        end
        for (int t = 0; t < 12; t++)
        begin
            a = a * q;
            b = b * s;
        end
        if (a > b)
            return 1;
        else if (a < b)
            return -1;
        return 0;
    endfunction

    // sRGB byte to linear, rounded, ties up
    function automatic longint unsigned dec_value(longint unsigned lmax, longint unsigned i);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (i <= 10)
            return (64'd20 * lmax * i + 64'd32946) / 64'd65892;
        lo = 0;
        hi = lmax;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo + 1) >> 1);
            if (cmp_powers(2 * mid - 1, 10761, 2 * lmax, 40 * i + 561) <= 0)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic bit reaches(longint unsigned s, longint unsigned j,
                                   longint unsigned lmax);
        if (s * 64'd10000000 <= 64'd125232 * lmax)
            return (64'd16473 * s) >= (64'd10 * lmax * (2 * j - 1));
        return cmp_powers(s, 10761, 4 * lmax, 40 * j + 541) >= 0;
    endfunction

    // least four-sum that encodes to byte j or more
    function automatic longint unsigned thr_value(longint unsigned lmax, longint unsigned j);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        if (j == 0)
            return 0;
        lo = 0;
        hi = 4 * lmax;
        while (lo < hi)
        begin
            mid = lo + ((hi - lo) >> 1);
            if (reaches(mid, j, lmax))
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

endpackage

// ===== hw/rtl/srgb_front.sv =====
module srgb_front #(
    parameter int MAX_WIDTH   = srgb_pkg::DEF_MAX_WIDTH,
    parameter int LINEAR_BITS = srgb_pkg::DEF_LINEAR_BITS,
    localparam int COL_W  = $clog2(MAX_WIDTH) + 1,
    localparam int ROW_W  = $clog2(srgb_pkg::MAX_HEIGHT),
    localparam int SUM_W  = LINEAR_BITS + 2
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     restart,
    input  logic [COL_W-1:0]         width_eff,
    input  logic [ROW_W:0]           height_eff,
    input  logic                     srgb,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [23:0]              s_tdata,
    input  logic                     q_full,
    output logic                     q_push,
    output logic [3*SUM_W-1:0]       q_sums,
    output srgb_pkg::blk_ctl_t       q_ctl
);
    localparam int LB     = LINEAR_BITS;
    localparam int PAIR_W = LB + 1;
    localparam int SLOT_W = ($clog2(MAX_WIDTH) > 1) ? $clog2(MAX_WIDTH) - 1 : 1;
    localparam longint unsigned LMAX = (64'd1 << LB) - 64'd1;

    logic [LB-1:0] rom [0:255];
    for (genvar i = 0; i < 256; i++)
    begin : g_rom
        localparam logic [LB-1:0] VAL = LB'(srgb_pkg::dec_value(LMAX, i));
        assign rom[i] = VAL;
    end

    logic [COL_W-1:0]  col_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [PAIR_W-1:0] acc_reg [0:2];
    logic [3*PAIR_W-1:0] mem [0:(2**SLOT_W)-1];
    logic [3*PAIR_W-1:0] rd_reg;
    logic [PAIR_W-1:0] v [0:2];
    logic [PAIR_W-1:0] pair [0:2];
    logic [SLOT_W-1:0] slot;
    logic accept;
    logic col_end;
    logic row_end;
    logic [COL_W-1:0] col_last;
    logic [ROW_W:0]   row_last;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign slot     = col_reg[SLOT_W:1];
    assign col_end  = (col_reg == width_eff - COL_W'(1));
    assign row_end  = ({1'b0, row_reg} == height_eff - (ROW_W+1)'(1));
    assign col_last = {width_eff[COL_W-1:1], 1'b0} - COL_W'(1);
    assign row_last = {height_eff[ROW_W:1], 1'b0} - (ROW_W+1)'(1);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            v[c] = srgb ? PAIR_W'(rom[s_tdata[8*c +: 8]]) : PAIR_W'(s_tdata[8*c +: 8]);
            pair[c] = acc_reg[c] + v[c];
            q_sums[SUM_W*c +: SUM_W] = SUM_W'(rd_reg[PAIR_W*c +: PAIR_W]) + SUM_W'(pair[c]);
        end
    end

    assign q_push     = accept && col_reg[0] && row_reg[0];
    assign q_ctl.srgb = srgb;
    assign q_ctl.last = (col_reg == col_last) && ({1'b0, row_reg} == row_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (col_end)
            begin
                col_reg <= '0;
                row_reg <= row_end ? '0 : row_reg + ROW_W'(1);
            end
            else
                col_reg <= col_reg + COL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !col_reg[0])
        begin
            for (int c = 0; c < 3; c++)
                acc_reg[c] <= v[c];
            rd_reg <= mem[slot];
        end
        if (accept && col_reg[0] && !row_reg[0])
            mem[slot] <= {pair[2], pair[1], pair[0]};
    end

endmodule

// ===== hw/rtl/srgb_queue.sv =====
module srgb_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output logic [DATA_W-1:0] head
);
    localparam int DEPTH = srgb_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [DATA_W-1:0] buf_reg [0:DEPTH-1];
    logic [AW-1:0] wr_reg;
    logic [AW-1:0] rd_reg;
    logic [AW:0]   cnt_reg;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign head  = buf_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + AW'(1);
            if (pop)
                rd_reg <= rd_reg + AW'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (AW+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (AW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wr_reg] <= push_data;
    end

endmodule

// ===== hw/rtl/srgb_back.sv =====
module srgb_back #(
    parameter int LINEAR_BITS = srgb_pkg::DEF_LINEAR_BITS,
    localparam int SUM_W = LINEAR_BITS + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  logic [3*SUM_W-1:0]   q_sums,
    input  srgb_pkg::blk_ctl_t   q_ctl,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast
);
    localparam int NS = srgb_pkg::SEARCH_STAGES;
    localparam longint unsigned LMAX = (64'd1 << LINEAR_BITS) - 64'd1;

    logic [SUM_W-1:0] thr [0:255];
    for (genvar j = 0; j < 256; j++)
    begin : g_thr
        localparam logic [SUM_W-1:0] VAL = SUM_W'(srgb_pkg::thr_value(LMAX, j));
        assign thr[j] = VAL;
    end

    logic               vld_reg [0:NS];
    logic [SUM_W-1:0]   s_reg   [0:NS][0:2];
    logic [7:0]         n_reg   [0:NS][0:2];
    srgb_pkg::blk_ctl_t ctl_reg [0:NS];
    logic [7:0]         cand    [0:NS-1][0:2];
    logic [7:0]         n_nxt   [0:NS-1][0:2];
    logic [SUM_W:0]     rnd     [0:2];
    logic               out_vld_reg;
    logic [23:0]        out_data_reg;
    logic               out_last_reg;
    logic               en;

    assign en       = !out_vld_reg || m_tready;
    assign q_pop    = en && q_valid;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // binary search for the highest byte whose threshold is at or below the sum
    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                cand[k][c]  = n_reg[k][c] | (8'h80 >> k);
                n_nxt[k][c] = (thr[cand[k][c]] <= s_reg[k][c]) ? cand[k][c] : n_reg[k][c];
            end
        end
        for (int c = 0; c < 3; c++)
            rnd[c] = {1'b0, s_reg[NS][c]} + (SUM_W+1)'(2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NS; k++)
                vld_reg[k] <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= q_valid;
            for (int k = 0; k < NS; k++)
                vld_reg[k+1] <= vld_reg[k];
            out_vld_reg <= vld_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= q_ctl;
            for (int c = 0; c < 3; c++)
            begin
                s_reg[0][c] <= q_sums[SUM_W*c +: SUM_W];
                n_reg[0][c] <= 8'd0;
            end
            for (int k = 0; k < NS; k++)
            begin
                ctl_reg[k+1] <= ctl_reg[k];
                for (int c = 0; c < 3; c++)
                begin
                    s_reg[k+1][c] <= s_reg[k][c];
                    n_reg[k+1][c] <= n_nxt[k][c];
                end
            end
            out_last_reg <= ctl_reg[NS].last;
            for (int c = 0; c < 3; c++)
                out_data_reg[8*c +: 8] <= ctl_reg[NS].srgb ? n_reg[NS][c] : rnd[c][9:2];
        end
    end

endmodule

// ===== hw/rtl/srgb_box_downsample_2x2.sv =====
// 2x2 box-filter mipmap reduction of an RGB888 raster stream. One pixel per
// clock is accepted while the queue is not full; one output beat (R in bits
// 7:0, G 15:8, B 23:16, tlast on the frame's final output) follows each
// completed 2x2 block once its sums have passed the queue and the search stages.
// The front end tracks position, maps bytes to linear through a ROM in sRGB
// mode and keeps even-row pair sums in a line memory of MAX_WIDTH/2 entries;
// a four-entry queue feeds an eight-stage threshold search that encodes back
// to sRGB, or in linear mode divides the four-sum by four, rounded. A write to
// any of the three registers restarts the frame and must only happen while the block is idle.
module srgb_box_downsample_2x2 #(
    parameter int MAX_WIDTH   = srgb_pkg::DEF_MAX_WIDTH,
    parameter int LINEAR_BITS = srgb_pkg::DEF_LINEAR_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [srgb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [srgb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [23:0]                          s_tdata,   // red_in, green_in, blue_in
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [23:0]                          m_tdata,   // red_out, green_out, blue_out
    output logic                                 m_tlast
);
    localparam int COL_W = $clog2(MAX_WIDTH) + 1;
    localparam int ROW_W = $clog2(srgb_pkg::MAX_HEIGHT);
    localparam int SUM_W = LINEAR_BITS + 2;
    localparam int QW    = 3 * SUM_W + $bits(srgb_pkg::blk_ctl_t);

    logic [srgb_pkg::WIDTH_BITS-1:0]  width_reg;
    logic [srgb_pkg::HEIGHT_BITS-1:0] height_reg;
    logic                             mode_reg;
    logic [COL_W-1:0]                 width_eff;
    logic [ROW_W:0]                   height_eff;

    logic                q_push;
    logic [3*SUM_W-1:0]  f_sums;
    srgb_pkg::blk_ctl_t  f_ctl;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    logic [QW-1:0]       q_head;
    srgb_pkg::blk_ctl_t  b_ctl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= srgb_pkg::RESET_WIDTH;
            height_reg <= srgb_pkg::RESET_HEIGHT;
            mode_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                srgb_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data[srgb_pkg::WIDTH_BITS-1:0];
                srgb_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                srgb_pkg::REG_SRGB_MODE:    mode_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            width_eff = COL_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            width_eff = COL_W'(MAX_WIDTH);
        else
            width_eff = COL_W'(width_reg);
        if (height_reg == '0)
            height_eff = (ROW_W+1)'(1);
        else if (32'(height_reg) > srgb_pkg::MAX_HEIGHT)
            height_eff = (ROW_W+1)'(srgb_pkg::MAX_HEIGHT);
        else
            height_eff = (ROW_W+1)'(height_reg);
    end

    srgb_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .LINEAR_BITS (LINEAR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .restart    (cfg_we && (cfg_index == srgb_pkg::REG_IMAGE_WIDTH ||
                                cfg_index == srgb_pkg::REG_IMAGE_HEIGHT ||
                                cfg_index == srgb_pkg::REG_SRGB_MODE)),
        .width_eff  (width_eff),
        .height_eff (height_eff),
        .srgb       (mode_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_sums     (f_sums),
        .q_ctl      (f_ctl)
    );

    srgb_queue #(
        .DATA_W (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_ctl, f_sums}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign b_ctl = q_head[QW-1 -: $bits(srgb_pkg::blk_ctl_t)];

    srgb_back #(
        .LINEAR_BITS (LINEAR_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_sums   (q_head[3*SUM_W-1:0]),
        .q_ctl    (b_ctl),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== hw/rtl/srgb_checker.sv =====
module srgb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);
    logic [39:0] in_cnt_reg;
    logic [39:0] out_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_cnt_reg <= in_cnt_reg + 40'd1;
            if (m_tvalid && m_tready)
                out_cnt_reg <= out_cnt_reg + 40'd1;
        end
    end

    // every output beat needs four input beats of its own
    a_out_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg << 2) <= in_cnt_reg)
        else $error("output beat without a full block of input");

    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid right after reset");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

endmodule

bind srgb_box_downsample_2x2 srgb_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
